/* rtl/core/fet_pkg.sv */
// ----------------------------------------------------------------------------
// fet_pkg
// shared widths, payload structs and divider request/response types for the
// one-sided fisher exact unit
// ----------------------------------------------------------------------------
package fet_pkg;

    localparam int COUNT_W     = 10;
    localparam int COUNT_MAX   = 1023;
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LF_W        = 48;
    localparam int P_W         = 32;
    localparam int DIV_W       = 64;

    typedef struct packed {
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        logic [COUNT_W-1:0] count_c;
        logic [COUNT_W-1:0] count_d;
    } fet_in_t;

    typedef struct packed {
        logic [P_W-1:0] p_value;
        logic           saturated;
    } fet_out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

/* rtl/core/fet_div.sv */
// ----------------------------------------------------------------------------
// fet_div
// radix-2 restoring divider, one quotient bit per cycle, done pulses once
// when quotient and remainder are ready
// ----------------------------------------------------------------------------
module fet_div import fet_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/core/fisher_exact_one_sided_unit.sv */
// ----------------------------------------------------------------------------
// fisher_exact_one_sided_unit
// one-sided fisher exact p-value of a 2x2 table, fixed point, built around one
// shared divider and one shared 32x32 multiplier under a sequencer
// ----------------------------------------------------------------------------
//  channel  dir  payload    handshake
//  s_*      in   fet_in_t   s_valid / s_ready
//  m_*      out  fet_out_t  m_valid / m_ready
//
//  after reset the log-factorial memory is built, one entry at a time, with a
//  chain of divisions per entry, and s_ready stays low until it is complete
//  a request sums min(a,d)+1 terms once the table is oriented; a term runs
//  a series of at most 39 steps, each dividing on the shared divider; the
//  result waits in an output register, and the next request is taken once
//  the previous sum has been handed to that register
// ----------------------------------------------------------------------------
module fisher_exact_one_sided_unit import fet_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fet_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fet_out_t m_data
);

    localparam int MUL_W    = 32;
    localparam int Q_W      = ADDR_W + 1;
    localparam int Q2_W     = 2 * Q_W;
    localparam int CB_W     = COUNT_W + 1;
    localparam int DIFF_W   = LF_W + 6;
    localparam int LN_W     = 58;
    localparam int ACC_W    = 56;
    localparam int PROD_W   = 122;
    localparam int PACC_W   = 40;
    localparam int PTERM_W  = 34;
    localparam int J_W      = 6;
    localparam int KX_W     = 6;
    localparam int SH_W     = 7;
    localparam int XS_W     = 26;
    localparam int X_KEEP   = DIV_W - XS_W;
    localparam int RD_LAST  = 9;
    localparam int K_LIMIT  = 36;
    localparam int TAYLOR_MAX = 40;

    localparam logic [DIV_W-1:0]  BUILD_NUM = 64'd1 << 61;
    localparam logic [DIV_W-1:0]  ONE_Q58   = 64'd1 << 58;
    localparam logic [DIFF_W-1:0] X_LIMIT   = 54'd23 << 32;
    localparam logic [PACC_W-1:0] ONE_Q32   = 40'd1 << 32;
    localparam logic [PACC_W-1:0] MASK_Q32  = ONE_Q32 - 40'd1;

    typedef enum logic [4:0] {
        ST_BZERO, ST_BQ, ST_BW0, ST_BLOOP, ST_BWDIV, ST_BTDIV, ST_BLN, ST_BACC,
        ST_BWR, ST_IDLE, ST_ORD1, ST_ORD2, ST_ORD3, ST_RD, ST_XCHK, ST_KDIV,
        ST_TLOOP, ST_MUL, ST_TDIVST, ST_TDIV, ST_RND, ST_ACC, ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          k_reg, k_next;
    logic [Q2_W-1:0]            q2_reg, q2_next;
    logic [DIV_W-1:0]           term_reg, term_next;
    logic [DIV_W-1:0]           sum_reg, sum_next;
    logic [J_W-1:0]             j_reg, j_next;
    logic [DIV_W-1:0]           lnk_reg, lnk_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [LN_W-1:0]            ln2_reg, ln2_next;
    logic [COUNT_W-1:0]         ca_reg, ca_next;
    logic [CB_W-1:0]            cb_reg, cb_next;
    logic [CB_W-1:0]            cc_reg, cc_next;
    logic [COUNT_W-1:0]         cd_reg, cd_next;
    logic [2*COUNT_W-1:0]       ad_reg, ad_next;
    logic [3:0]                 rd_idx_reg, rd_idx_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic [KX_W-1:0]            kx_reg, kx_next;
    logic [LN_W-1:0]            r_reg, r_next;
    logic [2:0]                 pp_reg, pp_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [PTERM_W-1:0]         pterm_reg, pterm_next;
    logic [PACC_W-1:0]          pacc_reg, pacc_next;
    logic [2*MUL_W-1:0]         mul_reg, mul_next;
    logic                       m_valid_reg, m_valid_next;
    fet_out_t                   m_data_reg, m_data_next;

    logic [LF_W-1:0]            rom_mem [TABLE_DEPTH];
    logic [LF_W-1:0]            rom_rd_reg;
    logic                       rom_we;
    logic [ADDR_W-1:0]          rom_waddr;
    logic [LF_W-1:0]            rom_wdata;
    logic [ADDR_W-1:0]          rom_raddr;
    logic [ADDR_W:0]            addr_sum;

    logic                       mul_en;
    logic [MUL_W-1:0]           mul_a, mul_b;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic [Q_W-1:0]             q_val;
    logic [DIV_W:0]             ln2_rnd;
    logic [DIV_W:0]             lnk_rnd;
    logic [ACC_W:0]             acc_rnd;
    logic                       swap;
    logic [CB_W-1:0]            a1, b1, c1, d1;
    logic signed [DIFF_W-1:0]   rom_ext;
    logic [DIFF_W-1:0]          xabs;
    logic                       rem_nz;
    logic [DIV_W:0]             kbig;
    logic [PROD_W-1:0]          pp_add;
    logic [SH_W-1:0]            shamt;
    logic [DIV_W:0]             rsum;
    logic [DIV_W:0]             rsh;
    logic [PACC_W-1:0]          psum;

    function automatic logic [COUNT_W-1:0] clamp_cnt(input logic [COUNT_W-1:0] v);
        clamp_cnt = (32'(v) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : v;
    endfunction

    fet_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign q_val   = {k_reg, 1'b0} - Q_W'(1);
    assign ln2_rnd = {1'b0, sum_reg} + 65'd2;
    assign lnk_rnd = {1'b0, lnk_reg} + (65'd1 << 19);
    assign acc_rnd = {1'b0, acc_reg} + 57'd128;

    assign swap = ad_reg > mul_reg[2*COUNT_W-1:0];
    assign a1   = swap ? cb_reg : CB_W'(ca_reg);
    assign b1   = swap ? CB_W'(ca_reg) : cb_reg;
    assign c1   = swap ? CB_W'(cd_reg) : cc_reg;
    assign d1   = swap ? cc_reg : CB_W'(cd_reg);

    assign rom_ext = signed'({{(DIFF_W-LF_W){1'b0}}, rom_rd_reg});
    assign xabs    = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : '0;
    assign rem_nz  = |div_rsp.remainder;
    assign kbig    = {1'b0, div_rsp.quotient} + (DIV_W+1)'(rem_nz);

    assign shamt = SH_W'(XS_W) + SH_W'(kx_reg);
    assign rsum  = {1'b0, sum_reg} + ((DIV_W+1)'(1) << (shamt - SH_W'(1)));
    assign rsh   = rsum >> shamt;
    assign psum  = pacc_reg + PACC_W'(pterm_reg);

    // table read address for the current step of a term
    always_comb begin
        case (rd_idx_reg)
            4'd0:    addr_sum = (ADDR_W+1)'(ca_reg) + (ADDR_W+1)'(cb_reg);
            4'd1:    addr_sum = (ADDR_W+1)'(cc_reg) + (ADDR_W+1)'(cd_reg);
            4'd2:    addr_sum = (ADDR_W+1)'(ca_reg) + (ADDR_W+1)'(cc_reg);
            4'd3:    addr_sum = (ADDR_W+1)'(cb_reg) + (ADDR_W+1)'(cd_reg);
            4'd4:    addr_sum = (ADDR_W+1)'(ca_reg);
            4'd5:    addr_sum = (ADDR_W+1)'(cb_reg);
            4'd6:    addr_sum = (ADDR_W+1)'(cc_reg);
            4'd7:    addr_sum = (ADDR_W+1)'(cd_reg);
            4'd8:    addr_sum = (ADDR_W+1)'(ca_reg) + (ADDR_W+1)'(cb_reg)
                              + (ADDR_W+1)'(cc_reg) + (ADDR_W+1)'(cd_reg);
            default: addr_sum = '0;
        endcase
        if (addr_sum >= (ADDR_W+1)'(TABLE_DEPTH)) begin
            rom_raddr = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            rom_raddr = addr_sum[ADDR_W-1:0];
        end
    end

    // partial product placement for the taylor multiply
    always_comb begin
        case (pp_reg)
            3'd1:    pp_add = PROD_W'(mul_reg);
            3'd2:    pp_add = PROD_W'(mul_reg) << 32;
            3'd3:    pp_add = PROD_W'(mul_reg) << 32;
            3'd4:    pp_add = PROD_W'(mul_reg) << 64;
            default: pp_add = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        q2_next      = q2_reg;
        term_next    = term_reg;
        sum_next     = sum_reg;
        j_next       = j_reg;
        lnk_next     = lnk_reg;
        acc_next     = acc_reg;
        ln2_next     = ln2_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        cc_next      = cc_reg;
        cd_next      = cd_reg;
        ad_next      = ad_reg;
        rd_idx_next  = rd_idx_reg;
        diff_next    = diff_reg;
        kx_next      = kx_reg;
        r_next       = r_reg;
        pp_next      = pp_reg;
        prod_next    = prod_reg;
        pterm_next   = pterm_reg;
        pacc_next    = pacc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        rom_we       = 1'b0;
        rom_waddr    = k_reg;
        rom_wdata    = '0;

        case (state_reg)
            // log-factorial build
            ST_BZERO: begin
                rom_we   = 1'b1;
                lnk_next = '0;
                acc_next = '0;
                k_next   = ADDR_W'(k_reg + 1'b1);
                if (k_reg == ADDR_W'(1)) begin
                    state_next = ST_BQ;
                end
            end
            ST_BQ: begin
                mul_en           = 1'b1;
                mul_a            = MUL_W'(q_val);
                mul_b            = MUL_W'(q_val);
                div_req.start    = 1'b1;
                div_req.dividend = BUILD_NUM;
                div_req.divisor  = DIV_W'(q_val);
                state_next       = ST_BW0;
            end
            ST_BW0: begin
                q2_next = mul_reg[Q2_W-1:0];
                if (div_rsp.done) begin
                    term_next  = div_rsp.quotient;
                    sum_next   = div_rsp.quotient;
                    j_next     = J_W'(1);
                    state_next = ST_BLOOP;
                end
            end
            ST_BLOOP: begin
                if (term_reg == '0) begin
                    state_next = ST_BLN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = term_reg;
                    div_req.divisor  = DIV_W'(q2_reg);
                    state_next       = ST_BWDIV;
                end
            end
            ST_BWDIV: begin
                if (div_rsp.done) begin
                    term_next = div_rsp.quotient;
                    if (div_rsp.quotient == '0) begin
                        state_next = ST_BLN;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = DIV_W'({j_reg, 1'b1});
                        state_next       = ST_BTDIV;
                    end
                end
            end
            ST_BTDIV: begin
                if (div_rsp.done) begin
                    sum_next   = sum_reg + div_rsp.quotient;
                    j_next     = J_W'(j_reg + 1'b1);
                    state_next = ST_BLOOP;
                end
            end
            ST_BLN: begin
                lnk_next = lnk_reg + sum_reg;
                if (k_reg == ADDR_W'(2)) begin
                    ln2_next = ln2_rnd[LN_W+1:2];
                end
                state_next = ST_BACC;
            end
            ST_BACC: begin
                acc_next   = acc_reg + ACC_W'(lnk_rnd[DIV_W:20]);
                state_next = ST_BWR;
            end
            ST_BWR: begin
                rom_we    = 1'b1;
                rom_wdata = acc_rnd[LF_W+7:8];
                k_next    = ADDR_W'(k_reg + 1'b1);
                if (k_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_BQ;
                end
            end
            // request handling
            ST_IDLE: begin
                if (s_valid) begin
                    ca_next    = clamp_cnt(s_data.count_a);
                    cb_next    = CB_W'(clamp_cnt(s_data.count_b));
                    cc_next    = CB_W'(clamp_cnt(s_data.count_c));
                    cd_next    = clamp_cnt(s_data.count_d);
                    pacc_next  = '0;
                    state_next = ST_ORD1;
                end
            end
            ST_ORD1: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(ca_reg);
                mul_b      = MUL_W'(cd_reg);
                state_next = ST_ORD2;
            end
            ST_ORD2: begin
                ad_next    = mul_reg[2*COUNT_W-1:0];
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cb_reg);
                mul_b      = MUL_W'(cc_reg);
                state_next = ST_ORD3;
            end
            ST_ORD3: begin
                ca_next     = (a1 > d1) ? d1[COUNT_W-1:0] : a1[COUNT_W-1:0];
                cd_next     = (a1 > d1) ? a1[COUNT_W-1:0] : d1[COUNT_W-1:0];
                cb_next     = (b1 > c1) ? c1 : b1;
                cc_next     = (b1 > c1) ? b1 : c1;
                rd_idx_next = '0;
                diff_next   = '0;
                state_next  = ST_RD;
            end
            ST_RD: begin
                if (rd_idx_reg >= 4'd1 && rd_idx_reg <= 4'd4) begin
                    diff_next = diff_reg + rom_ext;
                end else if (rd_idx_reg != 4'd0) begin
                    diff_next = diff_reg - rom_ext;
                end
                rd_idx_next = rd_idx_reg + 4'd1;
                if (rd_idx_reg == 4'(RD_LAST)) begin
                    state_next = ST_XCHK;
                end
            end
            ST_XCHK: begin
                if (xabs >= X_LIMIT) begin
                    pterm_next = '0;
                    state_next = ST_ACC;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {xabs[X_KEEP-1:0], {XS_W{1'b0}}};
                    div_req.divisor  = DIV_W'(ln2_reg);
                    state_next       = ST_KDIV;
                end
            end
            ST_KDIV: begin
                if (div_rsp.done) begin
                    if (kbig > (DIV_W+1)'(K_LIMIT)) begin
                        pterm_next = '0;
                        state_next = ST_ACC;
                    end else begin
                        kx_next    = kbig[KX_W-1:0];
                        r_next     = rem_nz ? LN_W'(ln2_reg - div_rsp.remainder[LN_W-1:0])
                                            : '0;
                        term_next  = ONE_Q58;
                        sum_next   = ONE_Q58;
                        j_next     = J_W'(1);
                        state_next = ST_TLOOP;
                    end
                end
            end
            ST_TLOOP: begin
                if (j_reg < J_W'(TAYLOR_MAX) && term_reg != '0) begin
                    pp_next    = '0;
                    prod_next  = '0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_RND;
                end
            end
            ST_MUL: begin
                prod_next = prod_reg + pp_add;
                pp_next   = pp_reg + 3'd1;
                case (pp_reg)
                    3'd0: begin
                        mul_en = 1'b1;
                        mul_a  = term_reg[MUL_W-1:0];
                        mul_b  = r_reg[MUL_W-1:0];
                    end
                    3'd1: begin
                        mul_en = 1'b1;
                        mul_a  = term_reg[MUL_W-1:0];
                        mul_b  = MUL_W'(r_reg[LN_W-1:MUL_W]);
                    end
                    3'd2: begin
                        mul_en = 1'b1;
                        mul_a  = term_reg[DIV_W-1:MUL_W];
                        mul_b  = r_reg[MUL_W-1:0];
                    end
                    3'd3: begin
                        mul_en = 1'b1;
                        mul_a  = term_reg[DIV_W-1:MUL_W];
                        mul_b  = MUL_W'(r_reg[LN_W-1:MUL_W]);
                    end
                    default: begin
                        state_next = ST_TDIVST;
                    end
                endcase
            end
            ST_TDIVST: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg[121:58];
                div_req.divisor  = DIV_W'(j_reg);
                state_next       = ST_TDIV;
            end
            ST_TDIV: begin
                if (div_rsp.done) begin
                    term_next  = div_rsp.quotient;
                    sum_next   = sum_reg + div_rsp.quotient;
                    j_next     = J_W'(j_reg + 1'b1);
                    state_next = ST_TLOOP;
                end
            end
            ST_RND: begin
                pterm_next = rsh[PTERM_W-1:0];
                state_next = ST_ACC;
            end
            ST_ACC: begin
                pacc_next = (psum > ONE_Q32) ? ONE_Q32 : psum;
                if (ca_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    ca_next     = ca_reg - 1'b1;
                    cb_next     = cb_reg + 1'b1;
                    cc_next     = cc_reg + 1'b1;
                    cd_next     = cd_reg - 1'b1;
                    rd_idx_next = '0;
                    diff_next   = '0;
                    state_next  = ST_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    if (pacc_reg > MASK_Q32) begin
                        m_data_next.p_value   = '1;
                        m_data_next.saturated = 1'b1;
                    end else begin
                        m_data_next.p_value   = pacc_reg[P_W-1:0];
                        m_data_next.saturated = 1'b0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mul_next = mul_en ? (mul_a * mul_b) : mul_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_BZERO;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
        q2_reg     <= q2_next;
        term_reg   <= term_next;
        sum_reg    <= sum_next;
        j_reg      <= j_next;
        lnk_reg    <= lnk_next;
        acc_reg    <= acc_next;
        ln2_reg    <= ln2_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        cc_reg     <= cc_next;
        cd_reg     <= cd_next;
        ad_reg     <= ad_next;
        rd_idx_reg <= rd_idx_next;
        diff_reg   <= diff_next;
        kx_reg     <= kx_next;
        r_reg      <= r_next;
        pp_reg     <= pp_next;
        prod_reg   <= prod_next;
        pterm_reg  <= pterm_next;
        pacc_reg   <= pacc_next;
        mul_reg    <= mul_next;
        m_data_reg <= m_data_next;
    end

    // log-factorial memory
    always_ff @(posedge aclk) begin
        if (rom_we) begin
            rom_mem[rom_waddr] <= rom_wdata;
        end
        rom_rd_reg <= rom_mem[rom_raddr];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sim/fisher_exact_one_sided_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisher_exact_one_sided_unit_tb
// self-checking bench for the one-sided fisher exact unit: a short table of
// hand-picked 2x2 tables, then random tables, under three idle patterns on
// the two channels. a p-value is checked against its row's typed-in value if
// any, else against a bit-exact fixed-point model of the tail sum in the bench
// ----------------------------------------------------------------------------
module fisher_exact_one_sided_unit_tb;
    import fet_pkg::*;

    typedef bit [63:0] u64_t;

    typedef struct {
        bit       known;
        fet_out_t want;
    } typed_pvalue_t;

    typedef struct packed {
        fet_in_t  tbl;
        logic     known;
        fet_out_t want;
    } dir_row_t;

    localparam int       QUIET_LIMIT = 12_000_000;
    localparam int       TAIL_CYCLES = 200;
    localparam int       N_RANDOM    = 90;
    localparam fet_out_t ALL_ONES    = '{32'hFFFF_FFFF, 1'b1};
    localparam fet_out_t NO_EXP      = '0;

    localparam dir_row_t DIR_ROWS [22] = '{
        '{'{10'd0,    10'd0,    10'd0,    10'd0   }, 1'b1, ALL_ONES},
        '{'{10'd1023, 10'd0,    10'd0,    10'd0   }, 1'b1, ALL_ONES},
        '{'{10'd0,    10'd1023, 10'd0,    10'd0   }, 1'b1, ALL_ONES},
        '{'{10'd0,    10'd0,    10'd1023, 10'd0   }, 1'b1, ALL_ONES},
        '{'{10'd0,    10'd0,    10'd0,    10'd1023}, 1'b1, ALL_ONES},
        '{'{10'd1023, 10'd1023, 10'd0,    10'd0   }, 1'b1, ALL_ONES},
        '{'{10'd1023, 10'd0,    10'd1023, 10'd0   }, 1'b1, ALL_ONES},
        '{'{10'd0,    10'd0,    10'd7,    10'd9   }, 1'b1, ALL_ONES},
        '{'{10'd1,    10'd0,    10'd0,    10'd1   }, 1'b0, NO_EXP},
        '{'{10'd0,    10'd1,    10'd1,    10'd0   }, 1'b0, NO_EXP},
        '{'{10'd1,    10'd1,    10'd1,    10'd1   }, 1'b0, NO_EXP},
        '{'{10'd2,    10'd0,    10'd0,    10'd2   }, 1'b0, NO_EXP},
        '{'{10'd1023, 10'd1,    10'd1,    10'd1023}, 1'b0, NO_EXP},
        '{'{10'd1,    10'd1023, 10'd1023, 10'd1   }, 1'b0, NO_EXP},
        '{'{10'd0,    10'd512,  10'd512,  10'd0   }, 1'b0, NO_EXP},
        '{'{10'd682,  10'd3,    10'd2,    10'd341 }, 1'b0, NO_EXP},
        '{'{10'd341,  10'd0,    10'd682,  10'd1   }, 1'b0, NO_EXP},
        '{'{10'd3,    10'd1000, 10'd900,  10'd2   }, 1'b0, NO_EXP},
        '{'{10'd100,  10'd2,    10'd3,    10'd100 }, 1'b0, NO_EXP},
        '{'{10'd17,   10'd20,   10'd15,   10'd40  }, 1'b0, NO_EXP},
        '{'{10'd5,    10'd5,    10'd5,    10'd5   }, 1'b0, NO_EXP},
        '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NO_EXP}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    fet_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    fet_out_t m_data;

    u64_t          log_fact_rom [TABLE_DEPTH];
    u64_t          ln2_q58;
    fet_out_t      pvalue_exp_q [$];
    typed_pvalue_t typed_pvalue_q [$];
    int            src_idle_pct;
    int            dst_idle_pct;
    int            quiet_cycles;
    int            mismatches;
    int            n_tables;
    int            n_typed;
    int            n_results;
    int            n_clipped;
    int            longest_tail;
    int            tail_terms;
    typed_pvalue_t plan;
    fet_out_t      model_out;
    fet_out_t      want_out;

    fisher_exact_one_sided_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ln(k) - ln(k-1) in q60 as 2*atanh(1/(2k-1))
    function automatic u64_t ln_ratio_q60(input u64_t k);
        u64_t q;
        u64_t q2;
        u64_t w;
        u64_t sum;
        u64_t j;
        q   = 2 * k - 1;
        q2  = q * q;
        w   = (u64_t'(1) << 61) / q;
        sum = w;
        j   = 1;
        while (w != 0) begin
            w   = w / q2;
            sum = sum + w / (2 * j + 1);
            j++;
        end
        return sum;
    endfunction

    function automatic u64_t log_fact(input int unsigned idx);
        if (idx >= TABLE_DEPTH) begin
            idx = TABLE_DEPTH - 1;
        end
        return log_fact_rom[idx];
    endfunction

    function automatic u64_t mul_shr(input u64_t x, input u64_t y, input int s);
        bit [127:0] prod;
        prod = (128'(x) * 128'(y)) >> s;
        return prod[63:0];
    endfunction

    function automatic u64_t exp_neg_q32(input u64_t x);
        u64_t x58;
        u64_t k;
        u64_t r;
        u64_t term;
        u64_t sum;
        int   s;
        if (x >= (u64_t'(23) << 32)) begin
            return 0;
        end
        x58 = x << 26;
        k   = (x58 + ln2_q58 - 1) / ln2_q58;
        if (k > 36) begin
            return 0;
        end
        r    = k * ln2_q58 - x58;
        term = u64_t'(1) << 58;
        sum  = term;
        for (int j = 1; j < 40 && term != 0; j++) begin
            term = mul_shr(term, r, 58) / u64_t'(j);
            sum  = sum + term;
        end
        s = 26 + int'(k);
        return (sum + (u64_t'(1) << (s - 1))) >> s;
    endfunction

    function automatic u64_t hypergeom_q32(input int unsigned a, input int unsigned b,
                                           input int unsigned c, input int unsigned d);
        u64_t pos;
        u64_t neg;
        pos = log_fact(a + b) + log_fact(c + d) + log_fact(a + c) + log_fact(b + d);
        neg = log_fact(a) + log_fact(b) + log_fact(c) + log_fact(d)
            + log_fact(a + b + c + d);
        return exp_neg_q32((neg > pos) ? neg - pos : 0);
    endfunction

    function automatic fet_out_t predict_pvalue(input fet_in_t tbl, output int n_terms);
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        int unsigned t;
        u64_t        acc;
        fet_out_t    res;
        a = tbl.count_a;
        b = tbl.count_b;
        c = tbl.count_c;
        d = tbl.count_d;
        if (a > COUNT_MAX) a = COUNT_MAX;
        if (b > COUNT_MAX) b = COUNT_MAX;
        if (c > COUNT_MAX) c = COUNT_MAX;
        if (d > COUNT_MAX) d = COUNT_MAX;
        if (u64_t'(a) * d > u64_t'(b) * c) begin
            t = a; a = b; b = t;
            t = c; c = d; d = t;
        end
        if (a > d) begin
            t = a; a = d; d = t;
        end
        if (b > c) begin
            t = b; b = c; c = t;
        end
        acc     = 0;
        n_terms = 0;
        forever begin
            acc = acc + hypergeom_q32(a, b, c, d);
            if (acc > (u64_t'(1) << 32)) begin
                acc = u64_t'(1) << 32;
            end
            n_terms++;
            if (a == 0) break;
            a--; b++; c++; d--;
        end
        if (acc > 64'hFFFF_FFFF) begin
            res = ALL_ONES;
        end else begin
            res.p_value   = acc[31:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [COUNT_W-1:0] wide_count();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return COUNT_W'(COUNT_MAX);
        end
        return COUNT_W'($urandom_range(COUNT_MAX));
    endfunction

    // one small cell on each diagonal keeps the tail short
    function automatic fet_in_t random_table();
        fet_in_t tbl;
        int      mode;
        int      lim;
        mode = $urandom_range(99);
        lim  = (mode < 80) ? 3 : 12;
        if (mode >= 95) begin
            tbl.count_a = COUNT_W'($urandom_range(31));
            tbl.count_b = COUNT_W'($urandom_range(31));
            tbl.count_c = COUNT_W'($urandom_range(31));
            tbl.count_d = COUNT_W'($urandom_range(31));
        end else begin
            tbl.count_a = wide_count();
            tbl.count_b = wide_count();
            tbl.count_c = wide_count();
            tbl.count_d = wide_count();
            if ($urandom_range(1) != 0) begin
                tbl.count_a = COUNT_W'($urandom_range(lim));
            end else begin
                tbl.count_d = COUNT_W'($urandom_range(lim));
            end
            if ($urandom_range(1) != 0) begin
                tbl.count_b = COUNT_W'($urandom_range(lim));
            end else begin
                tbl.count_c = COUNT_W'($urandom_range(lim));
            end
        end
        return tbl;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, seen);
        end
    endtask

    task automatic send_table(input fet_in_t tbl, input bit known, input fet_out_t want);
        int            gap;
        typed_pvalue_t pl;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pl.known = known;
        pl.want  = want;
        typed_pvalue_q.push_back(pl);
        s_valid <= 1'b1;
        s_data  <= tbl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pvalue_exp_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (s_valid && s_ready) begin
                quiet_cycles = 0;
                plan      = typed_pvalue_q.pop_front();
                model_out = predict_pvalue(s_data, tail_terms);
                if (tail_terms > longest_tail) longest_tail = tail_terms;
                pvalue_exp_q.push_back(plan.known ? plan.want : model_out);
                n_tables++;
            end
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                n_results++;
                if (m_data.saturated) n_clipped++;
                if (pvalue_exp_q.size() == 0) begin
                    log_mismatch("unexpected request result", '0, m_data.p_value);
                end else begin
                    want_out = pvalue_exp_q.pop_front();
                    if (m_data.p_value !== want_out.p_value) begin
                        log_mismatch("p_value", want_out.p_value, m_data.p_value);
                    end
                    if (m_data.saturated !== want_out.saturated) begin
                        log_mismatch("saturated", 32'(want_out.saturated),
                                     32'(m_data.saturated));
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        u64_t lnk;
        u64_t acc40;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        src_idle_pct = 33;
        dst_idle_pct = 71;
        quiet_cycles = 0;
        mismatches   = 0;
        n_tables     = 0;
        n_typed      = 0;
        n_results    = 0;
        n_clipped    = 0;
        longest_tail = 0;

        lnk   = 0;
        acc40 = 0;
        log_fact_rom[0] = 0;
        log_fact_rom[1] = 0;
        for (int k = 2; k < TABLE_DEPTH; k++) begin
            lnk   = lnk + ln_ratio_q60(u64_t'(k));
            acc40 = acc40 + ((lnk + (u64_t'(1) << 19)) >> 20);
            log_fact_rom[k] = (acc40 + (u64_t'(1) << 7)) >> 8;
        end
        ln2_q58 = (ln_ratio_q60(2) + 2) >> 2;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 71 : 0;
            dst_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 33 : 0;
            if (phase == 0) begin
                foreach (DIR_ROWS[i]) begin
                    if (DIR_ROWS[i].known) n_typed++;
                    send_table(DIR_ROWS[i].tbl, DIR_ROWS[i].known, DIR_ROWS[i].want);
                end
            end
            for (int i = 0; i < N_RANDOM; i++) begin
                send_table(random_table(), 1'b0, NO_EXP);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d tables (%0d with typed-in p-values), %0d results back",
                 n_tables, n_typed, n_results);
        $display("%0d p-values clipped at one, longest tail %0d terms, %0d mismatches",
                 n_clipped, longest_tail, mismatches);
        if (mismatches == 0 && pvalue_exp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/fet_pkg.sv
rtl/core/fet_div.sv
rtl/core/fisher_exact_one_sided_unit.sv
sim/fisher_exact_one_sided_unit_tb.sv
